FILE: rtl/dmvp_pkg.sv
// dmvp_pkg: shared types, constants and glyph tables for the dot matrix packet block.
// Used by every module under rtl; depends on nothing.
package dmvp_pkg;

    localparam int DIM         = 14;
    localparam int FRAME_BYTES = 28;
    localparam int FRAME_MAX   = 64;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [5:0] POS_FRAME_FIRST = 6'd6;
    localparam logic [5:0] POS_FRAME_LAST  = 6'd33;
    localparam logic [5:0] POS_SUM         = 6'd34;
    localparam logic [5:0] POS_TERM        = 6'd35;
    localparam logic [5:0] POS_HDR_LAST    = 6'd5;
    localparam logic [7:0] TERM_BYTE       = 8'd22;

    localparam logic [7:0] HEADER [6] = '{8'd16, 8'd104, 8'd1, 8'd5, 8'd29, 8'd1};

    localparam logic [1:0] REG_PRIMARY   = 2'd0;
    localparam logic [1:0] REG_SECONDARY = 2'd1;
    localparam logic [1:0] REG_ROTATION  = 2'd2;

    localparam logic [2:0] UNIT_SINGLE = 3'd4;

    localparam logic [1:0] ROT_NONE = 2'd0;
    localparam logic [1:0] ROT_90   = 2'd1;
    localparam logic [1:0] ROT_180  = 2'd2;
    localparam logic [1:0] ROT_270  = 2'd3;

    typedef struct packed {
        logic [9:0] primary_value;
        logic [9:0] secondary_value;
    } t_in_item;

    typedef struct packed {
        logic [7:0] packet_byte;
        logic [5:0] byte_position;
        logic       last_byte;
    } t_out_item;

    typedef struct packed {
        logic [1:0] primary_unit;
        logic [2:0] secondary_unit;
        logic [1:0] rotation;
    } t_cfg;

    typedef logic [DIM-1:0][DIM-1:0]   t_grid;
    typedef logic [FRAME_BYTES-1:0][7:0] t_frame;
    typedef logic [0:4][2:0]           t_dglyph;
    typedef logic [0:4][4:0]           t_uglyph;

    typedef enum logic [2:0] {
        FE_IDLE,
        FE_HUND,
        FE_REM,
        FE_TENS,
        FE_ONES,
        FE_PUSH
    } t_fe_state;

    function automatic t_dglyph digit_glyph(logic [3:0] d);
        t_dglyph g;
        unique case (d)
            4'd0:    g = '{3'd7, 3'd5, 3'd5, 3'd5, 3'd7};
            4'd1:    g = '{3'd2, 3'd6, 3'd2, 3'd2, 3'd7};
            4'd2:    g = '{3'd7, 3'd1, 3'd2, 3'd4, 3'd7};
            4'd3:    g = '{3'd7, 3'd1, 3'd7, 3'd1, 3'd7};
            4'd4:    g = '{3'd5, 3'd5, 3'd7, 3'd1, 3'd1};
            4'd5:    g = '{3'd7, 3'd4, 3'd7, 3'd1, 3'd7};
            4'd6:    g = '{3'd7, 3'd4, 3'd7, 3'd5, 3'd7};
            4'd7:    g = '{3'd7, 3'd1, 3'd2, 3'd2, 3'd2};
            4'd8:    g = '{3'd7, 3'd5, 3'd7, 3'd5, 3'd7};
            4'd9:    g = '{3'd7, 3'd5, 3'd7, 3'd1, 3'd7};
            default: g = '0;
        endcase
        return g;
    endfunction

    function automatic t_uglyph unit_glyph(logic [1:0] u);
        t_uglyph g;
        unique case (u)
            2'd0: g = '{5'd25, 5'd26, 5'd4,  5'd11, 5'd19};
            2'd1: g = '{5'd16, 5'd6,  5'd8,  5'd8,  5'd6};
            2'd2: g = '{5'd22, 5'd4,  5'd6,  5'd4,  5'd4};
            2'd3: g = '{5'd0,  5'd21, 5'd21, 5'd21, 5'd10};
        endcase
        return g;
    endfunction

    // bit of the column byte for dot pair i (weights 16,32,64,128,1,2,4)
    function automatic logic [2:0] row_weight_bit(int i);
        logic [2:0] b;
        if (i < 4) begin
            b = 3'(i + 4);
        end else begin
            b = 3'(i - 4);
        end
        return b;
    endfunction

endpackage

FILE: rtl/dmvp_front.sv
// dmvp_front: accepts items, splits readings into digits, renders, rotates and
// packs the dot matrix into 28 column bytes. Depends on dmvp_pkg.
module dmvp_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  dmvp_pkg::t_in_item i_item,
    input  dmvp_pkg::t_cfg     i_cfg,
    input  logic               i_q_full,
    output logic               o_push,
    output dmvp_pkg::t_frame   o_frame
);

    dmvp_pkg::t_fe_state r_state, n_state;

    logic [9:0] r_v1, r_v2;
    logic [3:0] r_hund1, r_hund2;
    logic [6:0] r_rem1, r_rem2;
    logic [3:0] r_tens1, r_tens2;
    logic [3:0] r_ones1, r_ones2;

    logic [15:0] w_q1, w_q2;
    logic [9:0]  w_sub1, w_sub2;
    logic [14:0] w_t1, w_t2;
    logic [6:0]  w_o1, w_o2;

    dmvp_pkg::t_grid w_grid, w_rot;
    dmvp_pkg::t_frame w_frame;

    // hundreds by reciprocal 41/4096, exact for 0..1023
    assign w_q1   = 16'(r_v1) * 16'd41;
    assign w_q2   = 16'(r_v2) * 16'd41;
    assign w_sub1 = r_v1 - 10'(r_hund1) * 10'd100;
    assign w_sub2 = r_v2 - 10'(r_hund2) * 10'd100;
    // tens by 205/2048
    assign w_t1   = 15'(r_rem1) * 15'd205;
    assign w_t2   = 15'(r_rem2) * 15'd205;
    assign w_o1   = r_rem1 - 7'(r_tens1) * 7'd10;
    assign w_o2   = r_rem2 - 7'(r_tens2) * 7'd10;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dmvp_pkg::FE_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            dmvp_pkg::FE_IDLE: begin
                if (i_valid) begin
                    r_v1 <= i_item.primary_value;
                    r_v2 <= i_item.secondary_value;
                end
            end
            dmvp_pkg::FE_HUND: begin
                r_hund1 <= w_q1[15:12];
                r_hund2 <= w_q2[15:12];
            end
            dmvp_pkg::FE_REM: begin
                r_rem1 <= w_sub1[6:0];
                r_rem2 <= w_sub2[6:0];
            end
            dmvp_pkg::FE_TENS: begin
                r_tens1 <= w_t1[14:11];
                r_tens2 <= w_t2[14:11];
            end
            dmvp_pkg::FE_ONES: begin
                r_ones1 <= w_o1[3:0];
                r_ones2 <= w_o2[3:0];
            end
            dmvp_pkg::FE_PUSH: begin
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dmvp_pkg::FE_IDLE: if (i_valid)   n_state = dmvp_pkg::FE_HUND;
            dmvp_pkg::FE_HUND:                n_state = dmvp_pkg::FE_REM;
            dmvp_pkg::FE_REM:                 n_state = dmvp_pkg::FE_TENS;
            dmvp_pkg::FE_TENS:                n_state = dmvp_pkg::FE_ONES;
            dmvp_pkg::FE_ONES:                n_state = dmvp_pkg::FE_PUSH;
            dmvp_pkg::FE_PUSH: if (!i_q_full) n_state = dmvp_pkg::FE_IDLE;
            default:                          n_state = dmvp_pkg::FE_IDLE;
        endcase
    end

    always_comb begin
        o_ready = (r_state == dmvp_pkg::FE_IDLE);
        o_push  = (r_state == dmvp_pkg::FE_PUSH) && !i_q_full;
    end

    function automatic dmvp_pkg::t_grid put_digit(dmvp_pkg::t_grid g_in, logic [3:0] d,
                                                  int row, int col);
        dmvp_pkg::t_grid g;
        dmvp_pkg::t_dglyph gl;
        g  = g_in;
        gl = dmvp_pkg::digit_glyph(d);
        if (d <= 4'd9) begin
            for (int r = 0; r < 5; r++) begin
                for (int c = 0; c < 3; c++) begin
                    if (row + r < dmvp_pkg::DIM && col + c < dmvp_pkg::DIM) begin
                        g[row + r][col + c] = gl[r][2 - c];
                    end
                end
            end
        end
        return g;
    endfunction

    function automatic dmvp_pkg::t_grid put_unit(dmvp_pkg::t_grid g_in, logic [1:0] u,
                                                 int col);
        dmvp_pkg::t_grid g;
        dmvp_pkg::t_uglyph gl;
        g  = g_in;
        gl = dmvp_pkg::unit_glyph(u);
        for (int r = 0; r < 5; r++) begin
            for (int c = 0; c < 5; c++) begin
                if (col + c < dmvp_pkg::DIM) begin
                    g[5 + r][col + c] = gl[r][4 - c];
                end
            end
        end
        return g;
    endfunction

    function automatic dmvp_pkg::t_grid draw_reading(dmvp_pkg::t_grid g_in,
                                                     logic [3:0] h, logic [3:0] t,
                                                     logic [3:0] o, int row,
                                                     logic [1:0] u);
        dmvp_pkg::t_grid g;
        g = g_in;
        if (h == 4'd0) begin
            g = put_digit(g, t, row, 1);
            g = put_digit(g, o, row, 5);
            g = put_unit(g, u, 9);
        end else begin
            g = put_digit(g, h, row, 1);
            g = put_digit(g, t, row, 5);
            g = put_digit(g, o, row, 9);
            g = put_unit(g, u, 13);
        end
        return g;
    endfunction

    always_comb begin
        w_grid = '0;
        if (i_cfg.secondary_unit < dmvp_pkg::UNIT_SINGLE) begin
            w_grid = draw_reading(w_grid, r_hund1, r_tens1, r_ones1, 1,
                                  i_cfg.primary_unit);
            w_grid = draw_reading(w_grid, r_hund2, r_tens2, r_ones2, 8,
                                  i_cfg.secondary_unit[1:0]);
        end else begin
            w_grid = draw_reading(w_grid, r_hund1, r_tens1, r_ones1, 5,
                                  i_cfg.primary_unit);
        end
    end

    always_comb begin
        for (int a = 0; a < dmvp_pkg::DIM; a++) begin
            for (int b = 0; b < dmvp_pkg::DIM; b++) begin
                unique case (i_cfg.rotation)
                    dmvp_pkg::ROT_NONE: w_rot[a][b] = w_grid[a][b];
                    dmvp_pkg::ROT_90:   w_rot[a][b] = w_grid[13 - b][a];
                    dmvp_pkg::ROT_180:  w_rot[a][b] = w_grid[13 - a][13 - b];
                    dmvp_pkg::ROT_270:  w_rot[a][b] = w_grid[b][13 - a];
                endcase
            end
        end
    end

    always_comb begin
        w_frame = '0;
        for (int j = 0; j < dmvp_pkg::DIM; j++) begin
            for (int i = 0; i < 7; i++) begin
                w_frame[j][dmvp_pkg::row_weight_bit(i)]      = w_rot[2 * i][j];
                w_frame[27 - j][dmvp_pkg::row_weight_bit(i)] = w_rot[2 * i + 1][j];
            end
        end
    end

    assign o_frame = w_frame;

endmodule

FILE: rtl/dmvp_fifo.sv
// dmvp_fifo: short queue of packed frames between the front and the back end.
// Depends on dmvp_pkg.
module dmvp_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  dmvp_pkg::t_frame i_frame,
    output logic             o_full,
    input  logic             i_pop,
    output dmvp_pkg::t_frame o_frame,
    output logic             o_empty
);

    localparam int PTR_W = $clog2(dmvp_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(dmvp_pkg::QUEUE_DEPTH + 1);

    dmvp_pkg::t_frame r_mem [dmvp_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_frame;
        end
    end

    assign o_frame = r_mem[r_rd];
    assign o_full  = (r_cnt == CNT_W'(dmvp_pkg::QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);

endmodule

FILE: rtl/dmvp_back.sv
// dmvp_back: walks the packet bytes of the head frame, one per cycle while the
// receiver is ready, into the output register, and forms the running checksum. Depends on dmvp_pkg.
module dmvp_back #(
    parameter int PACKET_BYTES = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_empty,
    input  dmvp_pkg::t_frame    i_q_frame,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_ready,
    output dmvp_pkg::t_out_item o_item
);

    localparam int COUNT = (PACKET_BYTES > dmvp_pkg::FRAME_MAX) ?
                           dmvp_pkg::FRAME_MAX : PACKET_BYTES;
    localparam logic [5:0] LAST_POS = 6'(COUNT - 1);

    logic [5:0] r_pos;
    logic [7:0] r_sum;
    logic       r_valid;
    dmvp_pkg::t_out_item r_item;

    logic       w_load;
    logic       w_last;
    logic [7:0] w_byte;
    logic [4:0] w_fidx;

    assign w_load = !i_q_empty && (!r_valid || i_ready);
    assign w_last = (r_pos == LAST_POS);
    assign w_fidx = 5'(r_pos - dmvp_pkg::POS_FRAME_FIRST);
    assign o_pop  = w_load && w_last;

    always_comb begin
        priority if (r_pos <= dmvp_pkg::POS_HDR_LAST) begin
            w_byte = dmvp_pkg::HEADER[r_pos[2:0]];
        end else if (r_pos <= dmvp_pkg::POS_FRAME_LAST) begin
            w_byte = i_q_frame[w_fidx];
        end else if (r_pos == dmvp_pkg::POS_SUM) begin
            w_byte = r_sum;
        end else if (r_pos == dmvp_pkg::POS_TERM) begin
            w_byte = dmvp_pkg::TERM_BYTE;
        end else begin
            w_byte = 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_valid <= 1'b1;
                r_pos   <= w_last ? 6'd0 : r_pos + 6'd1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_item.packet_byte   <= w_byte;
            r_item.byte_position <= r_pos;
            r_item.last_byte     <= w_last;
            if (r_pos == 6'd0) begin
                r_sum <= 8'd0;
            end else if (r_pos <= dmvp_pkg::POS_FRAME_LAST) begin
                r_sum <= r_sum + w_byte;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

FILE: rtl/dot_matrix_value_packet.sv
// dot_matrix_value_packet: top level with the register port, front end, frame
// queue and packet back end. Depends on dmvp_pkg, dmvp_front, dmvp_fifo, dmvp_back.
//
// Usage: an input item carries one or two 10-bit readings. Each item yields
// one packet of PACKET_BYTES (at most 64) result items, one per cycle while the
// receiver is ready: header, 28 matrix column bytes, checksum, terminator, zero
// fill. last_byte marks the final item of a packet.
// Each input item passes through the four digit steps, the render into the queue
// and the output register before its first byte appears.
// The byte walk of the back end sets the packet rate; the front end runs ahead
// into a two-frame queue, so input is taken while a packet is still being sent.
// Config registers (primary_unit at 0x0, secondary_unit at 0x4, rotation at 0x8)
// must be written by the user over the APB port while the block is idle; the block
// does not enforce it. Reset: units go to percent and single-line, rotation to
// none; queue and output register empty. A stalled receiver holds the current byte;
// the queue then fills and o_ready drops once the front end has a frame waiting.
module dot_matrix_value_packet #(
    parameter int PACKET_BYTES = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  dmvp_pkg::t_in_item  i_item,
    output logic                o_valid,
    input  logic                i_ready,
    output dmvp_pkg::t_out_item o_item,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    dmvp_pkg::t_cfg   r_cfg;
    logic             w_push, w_full, w_pop, w_empty;
    dmvp_pkg::t_frame w_front_frame, w_q_frame;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.primary_unit   <= 2'd0;
            r_cfg.secondary_unit <= dmvp_pkg::UNIT_SINGLE;
            r_cfg.rotation       <= dmvp_pkg::ROT_NONE;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[3:2])
                dmvp_pkg::REG_PRIMARY:   r_cfg.primary_unit   <= pwdata[1:0];
                dmvp_pkg::REG_SECONDARY: r_cfg.secondary_unit <= pwdata[2:0];
                dmvp_pkg::REG_ROTATION:  r_cfg.rotation       <= pwdata[1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            dmvp_pkg::REG_PRIMARY:   prdata = 32'(r_cfg.primary_unit);
            dmvp_pkg::REG_SECONDARY: prdata = 32'(r_cfg.secondary_unit);
            dmvp_pkg::REG_ROTATION:  prdata = 32'(r_cfg.rotation);
            default:                 prdata = 32'd0;
        endcase
    end

    assign pready = 1'b1;

    dmvp_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_item   (i_item),
        .i_cfg    (r_cfg),
        .i_q_full (w_full),
        .o_push   (w_push),
        .o_frame  (w_front_frame)
    );

    dmvp_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_frame (w_front_frame),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_frame (w_q_frame),
        .o_empty (w_empty)
    );

    dmvp_back #(
        .PACKET_BYTES (PACKET_BYTES)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (w_empty),
        .i_q_frame (w_q_frame),
        .o_pop     (w_pop),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_item    (o_item)
    );

endmodule

FILE: test/dmvp_packet_check.sv
// dmvp_packet_check: watches the item channels and the register port of the dot matrix
// packet block, predicts each packet of up to 64 bytes and compares every output item.
// Depends on dmvp_pkg.
module dmvp_packet_check #(
    parameter int PACKET_BYTES = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  dmvp_pkg::t_in_item  i_in_item,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  dmvp_pkg::t_out_item i_out_item,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    input  logic                pready,
    output int                  o_pending,
    output int                  o_mismatches
);
    import dmvp_pkg::*;

    typedef logic [0:DIM-1][0:DIM-1] t_dots;

    localparam int SENT_BYTES = (PACKET_BYTES > FRAME_MAX) ? FRAME_MAX : PACKET_BYTES;
    localparam int PRINT_LIMIT = 100;

    logic [1:0] primary_unit;
    logic [2:0] secondary_unit;
    logic [1:0] rotation;
    t_out_item  expected_bytes [$];

    function automatic logic [2:0] digit_row(int d, int r);
        logic [14:0] rows;
        case (d)
            0:       rows = {3'd7, 3'd5, 3'd5, 3'd5, 3'd7};
            1:       rows = {3'd2, 3'd6, 3'd2, 3'd2, 3'd7};
            2:       rows = {3'd7, 3'd1, 3'd2, 3'd4, 3'd7};
            3:       rows = {3'd7, 3'd1, 3'd7, 3'd1, 3'd7};
            4:       rows = {3'd5, 3'd5, 3'd7, 3'd1, 3'd1};
            5:       rows = {3'd7, 3'd4, 3'd7, 3'd1, 3'd7};
            6:       rows = {3'd7, 3'd4, 3'd7, 3'd5, 3'd7};
            7:       rows = {3'd7, 3'd1, 3'd2, 3'd2, 3'd2};
            8:       rows = {3'd7, 3'd5, 3'd7, 3'd5, 3'd7};
            9:       rows = {3'd7, 3'd5, 3'd7, 3'd1, 3'd7};
            default: rows = '0;
        endcase
        return rows[14 - 3 * r -: 3];
    endfunction

    // percent, celsius, fahrenheit, watts
    function automatic logic [4:0] unit_row(logic [1:0] u, int r);
        logic [24:0] rows;
        case (u)
            2'd0:    rows = {5'd25, 5'd26, 5'd4, 5'd11, 5'd19};
            2'd1:    rows = {5'd16, 5'd6, 5'd8, 5'd8, 5'd6};
            2'd2:    rows = {5'd22, 5'd4, 5'd6, 5'd4, 5'd4};
            default: rows = {5'd0, 5'd21, 5'd21, 5'd21, 5'd10};
        endcase
        return rows[24 - 5 * r -: 5];
    endfunction

    // quotients above nine leave the position blank
    function automatic t_dots put_digit(t_dots g, int d, int row, int col);
        logic [2:0] bits;
        int r;
        int c;
        if (d <= 9) begin
            for (r = 0; r < 5; r++) begin
                bits = digit_row(d, r);
                for (c = 0; c < 3; c++) begin
                    if (row + r < DIM && col + c < DIM) begin
                        g[row + r][col + c] = bits[2 - c];
                    end
                end
            end
        end
        return g;
    endfunction

    // unit glyph always has its top row at row 5, clipped at the right edge
    function automatic t_dots put_unit(t_dots g, logic [1:0] u, int col);
        logic [4:0] bits;
        int r;
        int c;
        for (r = 0; r < 5; r++) begin
            bits = unit_row(u, r);
            for (c = 0; c < 5; c++) begin
                if (col + c < DIM) begin
                    g[5 + r][col + c] = bits[4 - c];
                end
            end
        end
        return g;
    endfunction

    function automatic t_dots draw_reading(t_dots g, int v, int row, logic [1:0] u);
        if (v < 100) begin
            g = put_digit(g, v / 10, row, 1);
            g = put_digit(g, v % 10, row, 5);
            g = put_unit(g, u, 9);
        end else begin
            g = put_digit(g, v / 100, row, 1);
            g = put_digit(g, (v / 10) % 10, row, 5);
            g = put_digit(g, v % 10, row, 9);
            g = put_unit(g, u, 13);
        end
        return g;
    endfunction

    task automatic predict_packet(t_in_item it);
        t_dots      g;
        t_dots      t;
        logic [7:0] pkt [FRAME_MAX];
        logic [7:0] sum;
        logic [7:0] wt;
        t_out_item  o;
        int         i;
        int         j;
        g = '0;
        if (secondary_unit < UNIT_SINGLE) begin
            g = draw_reading(g, int'(it.primary_value), 1, primary_unit);
            g = draw_reading(g, int'(it.secondary_value), 8, secondary_unit[1:0]);
        end else begin
            g = draw_reading(g, int'(it.primary_value), 5, primary_unit);
        end
        for (i = 0; i < DIM; i++) begin
            for (j = 0; j < DIM; j++) begin
                case (rotation)
                    ROT_90:  t[j][DIM - 1 - i] = g[i][j];
                    ROT_180: t[DIM - 1 - i][DIM - 1 - j] = g[i][j];
                    ROT_270: t[DIM - 1 - j][i] = g[i][j];
                    default: t[i][j] = g[i][j];
                endcase
            end
        end
        for (i = 0; i < FRAME_MAX; i++) begin
            pkt[i] = 8'd0;
        end
        pkt[0] = 8'd16;
        pkt[1] = 8'd104;
        pkt[2] = 8'd1;
        pkt[3] = 8'd5;
        pkt[4] = 8'd29;
        pkt[5] = 8'd1;
        // even rows fill columns left to right, odd rows right to left
        for (j = 0; j < DIM; j++) begin
            for (i = 0; i < 7; i++) begin
                wt = (i < 4) ? (8'd16 << i) : (8'd1 << (i - 4));
                if (t[2 * i][j]) pkt[6 + j] = pkt[6 + j] | wt;
                if (t[2 * i + 1][j]) pkt[33 - j] = pkt[33 - j] | wt;
            end
        end
        sum = 8'd0;
        for (i = 1; i <= 33; i++) begin
            sum = sum + pkt[i];
        end
        pkt[34] = sum;
        pkt[35] = 8'd22;
        for (i = 0; i < SENT_BYTES; i++) begin
            o.packet_byte   = pkt[i];
            o.byte_position = 6'(i);
            o.last_byte     = (i == SENT_BYTES - 1);
            expected_bytes.push_back(o);
        end
    endtask

    task automatic report_mismatch(string what);
        o_mismatches++;
        if (o_mismatches <= PRINT_LIMIT) $display("%0t: %s", $time, what);
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            primary_unit   = 2'd0;
            secondary_unit = UNIT_SINGLE;
            rotation       = ROT_NONE;
            expected_bytes.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_bytes.size() == 0) begin
                    report_mismatch($sformatf("unexpected item: byte %0d at position %0d",
                        i_out_item.packet_byte, i_out_item.byte_position));
                end else begin
                    want = expected_bytes.pop_front();
                    if (i_out_item.packet_byte !== want.packet_byte)
                        report_mismatch($sformatf("packet_byte at %0d: got %0d, want %0d",
                            want.byte_position, i_out_item.packet_byte, want.packet_byte));
                    if (i_out_item.byte_position !== want.byte_position)
                        report_mismatch($sformatf("byte_position: got %0d, want %0d",
                            i_out_item.byte_position, want.byte_position));
                    if (i_out_item.last_byte !== want.last_byte)
                        report_mismatch($sformatf("last_byte at %0d: got %0b, want %0b",
                            want.byte_position, i_out_item.last_byte, want.last_byte));
                end
            end
            if (i_in_valid && i_in_ready) predict_packet(i_in_item);
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_PRIMARY:   primary_unit   = pwdata[1:0];
                    REG_SECONDARY: secondary_unit = pwdata[2:0];
                    REG_ROTATION:  rotation       = pwdata[1:0];
                    default:       ;
                endcase
            end
        end
        o_pending = expected_bytes.size();
    end

endmodule

FILE: test/testbench.sv
// testbench: drives readings and register writes into dot_matrix_value_packet with random
// idling and back-pressure; dmvp_packet_check predicts and compares the packets.
// Depends on dmvp_pkg, dot_matrix_value_packet and dmvp_packet_check.
module testbench;
    import dmvp_pkg::*;

    localparam logic [1:0] UNIT_PCT        = 2'd0;
    localparam logic [1:0] UNIT_CELSIUS    = 2'd1;
    localparam logic [1:0] UNIT_FAHRENHEIT = 2'd2;
    localparam logic [1:0] UNIT_WATTS      = 2'd3;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 20;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_ITEMS   = 45;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_ready;
    t_in_item   i_item;
    logic       o_valid;
    logic       i_ready;
    t_out_item  o_item;
    logic       psel;
    logic       penable;
    logic       pwrite;
    logic [3:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic       pready;

    int pending;
    int mismatches;
    bit idle_on = 1'b1;
    int hold_requests = 0;

    dot_matrix_value_packet DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_item  (o_item),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    dmvp_packet_check u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_ready   (o_ready),
        .i_in_item    (i_item),
        .i_out_valid  (o_valid),
        .i_out_ready  (i_ready),
        .i_out_item   (o_item),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .o_pending    (pending),
        .o_mismatches (mismatches)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        #400000;
        $display("Some tests failed");
        $finish;
    end

    // receiver: random stalls, plus one long hold counted here
    initial begin
        int served;
        served  = 0;
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_requests != served) begin
                served  = hold_requests;
                i_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            i_ready = !(idle_on && $urandom_range(99) < 28);
        end
    end

    function automatic logic [9:0] pick_reading();
        int unsigned sel;
        sel = $urandom_range(9);
        if (sel < 3) return 10'($urandom_range(99));
        if (sel < 5) return 10'($urandom_range(1023, 1000));
        return 10'($urandom_range(1023));
    endfunction

    task automatic offer_reading(logic [9:0] first, logic [9:0] second);
        while (idle_on && $urandom_range(99) < 28) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_item  = '{primary_value: first, secondary_value: second};
        i_valid = 1'b1;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        i_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic apb_write(logic [1:0] index, logic [31:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {index, 2'b00};
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic set_display(logic [1:0] first_unit, logic [2:0] second_unit,
                               logic [1:0] turn);
        wait_idle();
        apb_write(REG_PRIMARY, 32'(first_unit));
        apb_write(REG_SECONDARY, 32'(second_unit));
        apb_write(REG_ROTATION, 32'(turn));
    endtask

    initial begin
        logic [2:0] second_unit;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_item  = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        // single line, percent, no rotation after reset
        offer_reading(10'd0, 10'd0);
        offer_reading(10'd7, 10'd1023);
        offer_reading(10'd99, 10'd512);
        offer_reading(10'd100, 10'd0);
        offer_reading(10'd999, 10'd0);
        offer_reading(10'd1000, 10'd1);
        offer_reading(10'd1023, 10'd1023);

        set_display(UNIT_CELSIUS, 3'(UNIT_PCT), ROT_90);
        offer_reading(10'd0, 10'd1023);
        offer_reading(10'd1023, 10'd0);
        offer_reading(10'd55, 10'd100);

        set_display(UNIT_FAHRENHEIT, 3'(UNIT_WATTS), ROT_180);
        offer_reading(10'd999, 10'd1000);
        offer_reading(10'd12, 10'd345);

        set_display(UNIT_WATTS, 3'(UNIT_FAHRENHEIT), ROT_270);
        offer_reading(10'd1023, 10'd1023);
        offer_reading(10'd0, 10'd0);
        offer_reading(10'd678, 10'd9);

        set_display(UNIT_PCT, 3'(UNIT_CELSIUS), ROT_NONE);
        offer_reading(10'd88, 10'd88);
        offer_reading(10'd100, 10'd99);

        // undefined secondary codes fall back to single line
        set_display(UNIT_WATTS, 3'd7, ROT_90);
        offer_reading(10'd42, 10'd1023);
        set_display(UNIT_FAHRENHEIT, 3'd5, ROT_180);
        offer_reading(10'd1000, 10'd3);
        set_display(UNIT_CELSIUS, 3'd6, ROT_270);
        offer_reading(10'd5, 10'd0);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            if ($urandom_range(9) < 7) second_unit = 3'($urandom_range(3));
            else second_unit = 3'($urandom_range(7, 4));
            set_display(2'($urandom_range(3)), second_unit, 2'($urandom_range(3)));
            idle_on = (p != 5);
            if (p == 2) hold_requests++;
            repeat (PHASE_ITEMS) offer_reading(pick_reading(), pick_reading());
        end

        wait_idle();
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/dmvp_pkg.sv
rtl/dmvp_front.sv
rtl/dmvp_fifo.sv
rtl/dmvp_back.sv
rtl/dot_matrix_value_packet.sv
test/dmvp_packet_check.sv
test/testbench.sv
